// ----- rtl/core/scc_pkg.sv -----
// Shared types, sizes and helper functions for the separable circular convolution block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package scc_pkg;

  // Store and kernel dimensions.
  localparam int MAX_ROWS    = 256;
  localparam int MAX_COLUMNS = 256;
  localparam int MAX_TAPS    = 31;
  localparam int MAX_DIM     = (MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS;

  // Field widths.
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLUMNS);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int DEPTH      = MAX_ROWS * MAX_COLUMNS;
  localparam int SIZE_W     = 9;
  localparam int TCNT_W     = 5;
  localparam int TIDX_W     = 5;
  localparam int TAP_W      = 16;
  localparam int PIX_W      = 32;
  localparam int PROD_W     = PIX_W + TAP_W + 1;
  localparam int ACC_W      = PROD_W + $clog2(MAX_TAPS + 1);
  localparam int LEN_W      = $clog2(MAX_DIM + 1);
  localparam int J_W        = $clog2(MAX_DIM + MAX_TAPS);
  localparam int CIDX_W     = 2;

  // Input word functions.
  typedef enum logic [1:0] {
    FN_LOAD_TAP = 2'd0,
    FN_WRITE    = 2'd1,
    FN_RUN      = 2'd2,
    FN_READ     = 2'd3
  } func_t;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_COLS = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_TAPS = 2'd2;

  // Round a Q.31 sum to Q15.16, half towards plus infinity, and saturate.
  function automatic logic signed [PIX_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0]      v;
    logic signed [ACC_W-15:0]   q;
    logic signed [PIX_W-1:0]    res;
    v = $signed({acc[ACC_W-1], acc}) + $signed((ACC_W+1)'(1 << 14));
    q = v[ACC_W:15];
    if (q > $signed((ACC_W-14)'({1'b0, {(PIX_W-1){1'b1}}}))) begin
      res = {1'b0, {(PIX_W-1){1'b1}}};
    end else if (q < -$signed((ACC_W-14)'({1'b1, {(PIX_W-1){1'b0}}}))) begin
      res = {1'b1, {(PIX_W-1){1'b0}}};
    end else begin
      res = q[PIX_W-1:0];
    end
    return res;
  endfunction

  // Clamp a size register to 1..hi.
  function automatic logic [LEN_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                  input logic [LEN_W-1:0] hi);
    logic [LEN_W-1:0] res;
    if (v == '0) begin
      res = LEN_W'(1);
    end else if (LEN_W'(v) > hi) begin
      res = hi;
    end else begin
      res = LEN_W'(v);
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/scc_cell.sv -----
// One cell of the transposed filter chain: multiplies the broadcast pixel by its tap
// and adds the partial sum handed over by its left neighbour. Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_cell import scc_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [TAP_W-1:0]        tap,
  input  logic signed [PIX_W-1:0] x,
  input  logic signed [ACC_W-1:0] sum_in,
  output logic signed [ACC_W-1:0] sum_out
);

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  sum_r;

  // Unsigned tap times signed pixel.
  assign prod = $signed({1'b0, tap}) * x;

  // Partial sum moves one cell along whenever a new pixel is broadcast.
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_in + ACC_W'(prod);
    end
  end

  assign sum_out = sum_r;

endmodule

// ----- rtl/core/separable_circular_convolution.sv -----
// Top level of the separable circular convolution block: stores, sequencer and cell chain.
// Depends on scc_pkg and scc_cell.
//
//   channel | direction | handshake            | words
//   in_     | input     | in_valid / in_stall  | tap load, pixel write, run, read
//   out_    | output    | out_valid / out_stall| filtered pixel and range flag
//   cfg_    | input     | cfg_valid / cfg_ready| register index and data
//
// Tap loads and pixel writes need no answer; a read is answered through the registered
// image memory port and the output register. A run streams each line of length len
// through the chain, wrapping around its end, for every row and then for every column,
// with preparation and draining per pass.
// Reset is synchronous and active low; the stores hold no reset value. The input is
// stalled during a run or a read and while a result waits that cannot be replaced.
`timescale 1ns / 1ps

module separable_circular_convolution import scc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_func,
  input  logic [TIDX_W-1:0]       in_tap_index,
  input  logic [TAP_W-1:0]        in_tap_value,
  input  logic [ROW_W-1:0]        in_row_index,
  input  logic [COL_W-1:0]        in_column_index,
  input  logic signed [PIX_W-1:0] in_pixel_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [PIX_W-1:0] out_result_value,
  output logic                    out_out_of_range,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CIDX_W-1:0]       cfg_index,
  input  logic [SIZE_W-1:0]       cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PREP   = 5'b00010,
    ST_FEED   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_RDWAIT = 5'b10000
  } state_t;

  typedef struct packed {
    logic             v;
    logic             wr;
    logic [LEN_W-1:0] c;
    logic [LEN_W-1:0] line;
  } tag_t;

  state_t                  state_r, state_nxt;
  logic [SIZE_W-1:0]       rows_cfg_r, cols_cfg_r;
  logic [TCNT_W-1:0]       taps_cfg_r;
  logic [TAP_W-1:0]        tap_r [MAX_TAPS];
  logic                    col_pass_r;
  logic [TCNT_W-1:0]       hm_r;
  logic [LEN_W-1:0]        src_r, start_r, line_r;
  logic [J_W-1:0]          j_r;
  tag_t                    tag0_r, tag1_r;
  logic                    out_valid_r, oor_r;
  logic signed [PIX_W-1:0] out_value_r;

  logic [LEN_W-1:0]        rows_eff, cols_eff, len, lines;
  logic [TCNT_W-1:0]       taps_eff, half;
  logic                    in_acc;
  logic [ADDR_W-1:0]       feed_addr, dest_addr, img_raddr, img_waddr;
  logic                    img_we, int_we;
  logic signed [PIX_W-1:0] img_wdata, img_q_r, int_q_r, x_bc, res_pix;
  logic signed [PIX_W-1:0] img_mem [DEPTH];
  logic signed [PIX_W-1:0] int_mem [DEPTH];
  logic signed [ACC_W-1:0] chain [MAX_TAPS+1];

  // Effective sizes.
  assign rows_eff = clamp_size(rows_cfg_r, LEN_W'(MAX_ROWS));
  assign cols_eff = clamp_size(cols_cfg_r, LEN_W'(MAX_COLUMNS));
  assign taps_eff = (taps_cfg_r > TCNT_W'(MAX_TAPS)) ? TCNT_W'(MAX_TAPS) : taps_cfg_r;
  assign half     = taps_eff >> 1;
  assign len      = col_pass_r ? rows_eff : cols_eff;
  assign lines    = col_pass_r ? cols_eff : rows_eff;

  // Handshakes.
  assign in_stall  = !((state_r == ST_IDLE) && (!out_valid_r || !out_stall));
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_out_of_range = oor_r;

  // Memory addressing: a row pass walks columns, a column pass walks rows.
  assign feed_addr = col_pass_r ? {src_r[ROW_W-1:0], line_r[COL_W-1:0]}
                                : {line_r[ROW_W-1:0], src_r[COL_W-1:0]};
  assign dest_addr = col_pass_r ? {tag1_r.c[ROW_W-1:0], tag1_r.line[COL_W-1:0]}
                                : {tag1_r.line[ROW_W-1:0], tag1_r.c[COL_W-1:0]};
  assign res_pix   = round_sat(chain[MAX_TAPS]);

  assign img_raddr = (state_r == ST_FEED) ? feed_addr : {in_row_index, in_column_index};
  assign img_we    = (in_acc && (in_func == FN_WRITE)) ||
                     (tag1_r.v && tag1_r.wr && col_pass_r);
  assign img_waddr = (state_r == ST_IDLE) ? {in_row_index, in_column_index} : dest_addr;
  assign img_wdata = (state_r == ST_IDLE) ? in_pixel_value : res_pix;
  assign int_we    = tag1_r.v && tag1_r.wr && !col_pass_r;

  // Image store.
  always_ff @(posedge clk) begin
    if (img_we) begin
      img_mem[img_waddr] <= img_wdata;
    end
    img_q_r <= img_mem[img_raddr];
  end

  // Intermediate store.
  always_ff @(posedge clk) begin
    if (int_we) begin
      int_mem[dest_addr] <= res_pix;
    end
    int_q_r <= int_mem[feed_addr];
  end

  // Cell chain, one cell per kernel position; unused positions see a zero tap.
  assign x_bc     = col_pass_r ? int_q_r : img_q_r;
  assign chain[0] = '0;

  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    logic [TAP_W-1:0] tap_eff;
    assign tap_eff = (TCNT_W'(i) < taps_eff) ? tap_r[i] : '0;
    scc_cell u_cell (
      .clk     (clk),
      .en      (tag0_r.v),
      .tap     (tap_eff),
      .x       (x_bc),
      .sum_in  (chain[i]),
      .sum_out (chain[i+1])
    );
  end

  // Tap store.
  always_ff @(posedge clk) begin
    if (in_acc && (in_func == FN_LOAD_TAP) && (in_tap_index < TIDX_W'(MAX_TAPS))) begin
      tap_r[in_tap_index] <= in_tap_value;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= SIZE_W'(256);
      cols_cfg_r <= SIZE_W'(256);
      taps_cfg_r <= TCNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROWS: rows_cfg_r <= cfg_data;
        CFG_COLS: cols_cfg_r <= cfg_data;
        CFG_TAPS: taps_cfg_r <= cfg_data[TCNT_W-1:0];
        default:  ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_func == FN_RUN)) begin
          state_nxt = ST_PREP;
        end else if (in_acc && (in_func == FN_READ)) begin
          state_nxt = ST_RDWAIT;
        end
      end
      ST_PREP: begin
        if (LEN_W'(hm_r) < len) begin
          state_nxt = ST_FEED;
        end
      end
      ST_FEED: begin
        if ((j_r == J_W'(len) + J_W'(MAX_TAPS - 2)) && (line_r == lines - LEN_W'(1))) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!tag0_r.v && !tag1_r.v) begin
          state_nxt = col_pass_r ? ST_IDLE : ST_PREP;
        end
      end
      ST_RDWAIT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer registers and the write-back tag pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tag0_r.v    <= 1'b0;
      tag1_r.v    <= 1'b0;
      out_valid_r <= 1'b0;
      col_pass_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tag0_r.v    <= (state_r == ST_FEED);
      tag1_r.v    <= tag0_r.v;
      tag0_r.wr   <= j_r >= J_W'(MAX_TAPS - 1);
      tag0_r.c    <= LEN_W'(j_r - J_W'(MAX_TAPS - 1));
      tag0_r.line <= line_r;
      tag1_r.wr   <= tag0_r.wr;
      tag1_r.c    <= tag0_r.c;
      tag1_r.line <= tag0_r.line;
      if (state_r == ST_RDWAIT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_IDLE) begin
        col_pass_r <= 1'b0;
      end else if ((state_r == ST_DRAIN) && !tag0_r.v && !tag1_r.v) begin
        col_pass_r <= 1'b1;
      end
    end
  end

  // Counters and payload registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        hm_r <= half;
        if (in_acc && (in_func == FN_READ)) begin
          oor_r <= ({1'b0, in_row_index} >= rows_eff) ||
                   ({1'b0, in_column_index} >= cols_eff);
        end
      end
      ST_PREP: begin
        // Reduce half the kernel modulo the line length, one subtraction a cycle.
        if (LEN_W'(hm_r) >= len) begin
          hm_r <= TCNT_W'(LEN_W'(hm_r) - len);
        end else begin
          src_r   <= (hm_r == '0) ? '0 : len - LEN_W'(hm_r);
          start_r <= (hm_r == '0) ? '0 : len - LEN_W'(hm_r);
          j_r     <= '0;
          line_r  <= '0;
        end
      end
      ST_FEED: begin
        if (j_r == J_W'(len) + J_W'(MAX_TAPS - 2)) begin
          j_r    <= '0;
          src_r  <= start_r;
          line_r <= line_r + LEN_W'(1);
        end else begin
          j_r   <= j_r + J_W'(1);
          src_r <= (src_r + LEN_W'(1) == len) ? '0 : src_r + LEN_W'(1);
        end
      end
      ST_DRAIN: hm_r <= half;
      ST_RDWAIT: out_value_r <= oor_r ? '0 : img_q_r;
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/scc_checker.sv -----
// Port-level checks for the separable circular convolution block, bound to the top level.
// Depends on scc_pkg and separable_circular_convolution.
`timescale 1ns / 1ps

module scc_checker import scc_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [1:0]              in_func,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [PIX_W-1:0] out_result_value,
  input logic                    out_out_of_range
);

  // A held result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // A held result word does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result_value) && $stable(out_out_of_range))
    else $error("result word changed while stalled");

  // An out-of-range read returns zero.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_result_value == '0)
    else $error("out-of-range read returned a non-zero value");

  // An accepted read is answered through the registered memory port and the output register.
  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func == FN_READ) |=> ##1 out_valid)
    else $error("read was not answered");

endmodule

bind separable_circular_convolution scc_checker u_scc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_func          (in_func),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_value (out_result_value),
  .out_out_of_range (out_out_of_range)
);
